### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the linked list manager.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtll: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtll: next-cycle check failed");

`endif

### design/mtll_pkg.sv
// ---------------------------------------------------------------------------
// mtll_pkg
// Types, codes and default sizes of the multi-trail linked list manager.
// ---------------------------------------------------------------------------
package mtll_pkg;

  localparam int NUM_SLOTS_DEF  = 256;
  localparam int MAX_TRAILS_DEF = 16;

  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 1;
  localparam int TRAIL_W  = 4;
  localparam int TCNT_W   = 5;

  localparam logic [FUNC_W-1:0]   FUNC_SPAWN    = 1'b0;
  localparam logic [FUNC_W-1:0]   FUNC_KILL     = 1'b1;
  localparam logic [STATUS_W-1:0] STATUS_DONE   = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_KILL,
    ST_REJECT
  } state_t;

  // Commands to the trail head table.
  typedef struct packed {
    logic take_rr;
    logic set_head;
  } head_ctl_t;

  // Commands to the link memories.
  typedef struct packed {
    logic rd_en;
    logic prev_we;
    logic trail_we;
    logic next_we;
  } mem_ctl_t;

endpackage

### design/mtll_if.sv
// ---------------------------------------------------------------------------
// mtll channel interfaces
// Valid/ready channels for requests, results and the trail count register.
// ---------------------------------------------------------------------------
interface mtll_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtll_pkg::FUNC_W-1:0] func;
  logic [mtll_pkg::SLOT_W-1:0] slot;

  modport source (output valid, func, slot, input ready);
  modport sink   (input valid, func, slot, output ready);
endinterface

interface mtll_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtll_pkg::STATUS_W-1:0] status;
  logic [mtll_pkg::TRAIL_W-1:0]  trail;
  logic [mtll_pkg::SLOT_W-1:0]   head_slot;
  logic                          head_empty;

  modport source (output valid, status, trail, head_slot, head_empty, input ready);
  modport sink   (input valid, status, trail, head_slot, head_empty, output ready);
endinterface

interface mtll_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mtll_pkg::TCNT_W-1:0] trail_count;

  modport source (output valid, trail_count, input ready);
  modport sink   (input valid, trail_count, output ready);
endinterface

### design/mtll_link_mem.sv
// ---------------------------------------------------------------------------
// mtll_link_mem
// Per-slot link storage: previous link and trail memories with their own write
// enables on a shared address, next link in a third memory. Reads are registered.
// ---------------------------------------------------------------------------
module mtll_link_mem #(
  parameter int NUM_SLOTS = mtll_pkg::NUM_SLOTS_DEF,
  parameter int TR_W      = 4,
  localparam int SIDX_W   = $clog2(NUM_SLOTS),
  localparam int LINK_W   = SIDX_W + 1
) (
  input  logic               clk,
  input  mtll_pkg::mem_ctl_t ctl,
  input  logic [SIDX_W-1:0]  rd_addr,
  input  logic [SIDX_W-1:0]  pw_addr,
  input  logic [LINK_W-1:0]  pw_prev,
  input  logic [TR_W-1:0]    pw_trail,
  input  logic [SIDX_W-1:0]  nw_addr,
  input  logic [LINK_W-1:0]  nw_next,
  output logic [LINK_W-1:0]  rd_prev_r,
  output logic [LINK_W-1:0]  rd_next_r,
  output logic [TR_W-1:0]    rd_trail_r
);

  logic [LINK_W-1:0] prev_mem  [NUM_SLOTS];
  logic [TR_W-1:0]   trail_mem [NUM_SLOTS];
  logic [LINK_W-1:0] next_mem  [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[pw_addr] <= pw_prev;
    end
    if (ctl.trail_we) begin
      trail_mem[pw_addr] <= pw_trail;
    end
    if (ctl.next_we) begin
      next_mem[nw_addr] <= nw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_prev_r  <= prev_mem[rd_addr];
      rd_trail_r <= trail_mem[rd_addr];
      rd_next_r  <= next_mem[rd_addr];
    end
  end

endmodule

### design/mtll_head_tbl.sv
// ---------------------------------------------------------------------------
// mtll_head_tbl
// Trail head registers, round-robin pointer and the trail count register.
// ---------------------------------------------------------------------------
module mtll_head_tbl #(
  parameter int NUM_SLOTS  = mtll_pkg::NUM_SLOTS_DEF,
  parameter int MAX_TRAILS = mtll_pkg::MAX_TRAILS_DEF,
  localparam int SIDX_W    = $clog2(NUM_SLOTS),
  localparam int LINK_W    = SIDX_W + 1,
  localparam int TR_W      = (MAX_TRAILS > 1) ? $clog2(MAX_TRAILS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mtll_pkg::TCNT_W-1:0] cfg_data,
  input  mtll_pkg::head_ctl_t         ctl,
  input  logic [TR_W-1:0]             rd_trail,
  input  logic [TR_W-1:0]             wr_trail,
  input  logic [LINK_W-1:0]           wr_link,
  output logic [TR_W-1:0]             rr_trail,
  output logic [LINK_W-1:0]           rd_link,
  output logic                        rd_in_use
);

  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {SIDX_W{1'b0}}};

  logic [mtll_pkg::TCNT_W-1:0] tc_r, tc_nxt;
  logic [TR_W-1:0]             rr_r, rr_nxt;
  logic [LINK_W-1:0]           heads_r [MAX_TRAILS];

  // Saturate the written count into the range 1 .. MAX_TRAILS.
  always_comb begin
    tc_nxt = cfg_data;
    if (cfg_data == '0) begin
      tc_nxt = mtll_pkg::TCNT_W'(1);
    end else if (32'(cfg_data) > MAX_TRAILS) begin
      tc_nxt = mtll_pkg::TCNT_W'(MAX_TRAILS);
    end
  end

  always_comb begin
    rr_trail = rr_r;
    if (32'(rr_r) >= 32'(tc_r)) begin
      rr_trail = '0;
    end
    if (32'(rr_trail) + 1 >= 32'(tc_r)) begin
      rr_nxt = '0;
    end else begin
      rr_nxt = rr_trail + TR_W'(1);
    end
  end

  assign rd_link   = heads_r[rd_trail];
  assign rd_in_use = (32'(rd_trail) < 32'(tc_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= mtll_pkg::TCNT_W'(1);
      rr_r <= '0;
      for (int i = 0; i < MAX_TRAILS; i++) begin
        heads_r[i] <= LINK_NONE;
      end
    end else if (cfg_we) begin
      tc_r <= tc_nxt;
      rr_r <= '0;
      for (int i = 0; i < MAX_TRAILS; i++) begin
        heads_r[i] <= LINK_NONE;
      end
    end else begin
      if (ctl.take_rr) begin
        rr_r <= rr_nxt;
      end
      if (ctl.set_head) begin
        heads_r[wr_trail] <= wr_link;
      end
    end
  end

endmodule

### design/multi_trail_linked_list_manager_top.sv
// ---------------------------------------------------------------------------
// multi_trail_linked_list_manager_top
// Several doubly linked lists over a fixed slot pool, one request at a time.
// ---------------------------------------------------------------------------
// Each request has an accept cycle and a completion cycle: in the accept cycle the live mark is checked
// and a spawn writes the new head entry (or a kill reads its entry from the
// link memories), and in the completion cycle the neighbor links are patched
// from the registered read data and the result is loaded. No new request is
// accepted until the completion cycle is done; the completion cycle
// waits while the result register is still full. There is no clearing pass
// after reset: live marks are flip-flops and the link memories are read only
// for live slots. Writing the trail count empties every trail and restarts
// the round-robin at trail 0.
module multi_trail_linked_list_manager_top #(
  parameter int NUM_SLOTS  = mtll_pkg::NUM_SLOTS_DEF,
  parameter int MAX_TRAILS = mtll_pkg::MAX_TRAILS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mtll_in_if.sink     in_req,
  mtll_out_if.source  out_res,
  mtll_cfg_if.sink    cfg_wr
);

  `include "assert_macros.svh"

  localparam int SIDX_W = $clog2(NUM_SLOTS);
  localparam int LINK_W = SIDX_W + 1;
  localparam int TR_W   = (MAX_TRAILS > 1) ? $clog2(MAX_TRAILS) : 1;
  localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {SIDX_W{1'b0}}};

  mtll_pkg::state_t state_r, state_nxt;

  logic [SIDX_W-1:0]    slot_r;
  logic [LINK_W-1:0]    old_r;
  logic [TR_W-1:0]      t_r;
  logic [NUM_SLOTS-1:0] live_r;

  logic                            out_valid_r;
  logic [mtll_pkg::STATUS_W-1:0]   out_status_r;
  logic [mtll_pkg::TRAIL_W-1:0]    out_trail_r;
  logic [mtll_pkg::SLOT_W-1:0]     out_head_r;
  logic                            out_empty_r;

  logic              in_fire, in_range, in_reject, slot_live, out_free;
  logic [SIDX_W-1:0] sidx;

  // Controls from the output decode.
  logic                          in_rdy, res_load, live_set, live_clr;
  logic [mtll_pkg::STATUS_W-1:0] res_status;
  logic [TR_W-1:0]               res_trail;
  logic [LINK_W-1:0]             res_link;

  mtll_pkg::head_ctl_t head_ctl;
  logic [TR_W-1:0]     head_rd_trail, head_wr_trail, rr_trail;
  logic [LINK_W-1:0]   head_wr_link, head_rd_link;
  logic                head_in_use;

  mtll_pkg::mem_ctl_t mem_ctl;
  logic [SIDX_W-1:0]  pw_addr, nw_addr;
  logic [LINK_W-1:0]  pw_prev, nw_next, rd_prev, rd_next;
  logic [TR_W-1:0]    pw_trail, rd_trail;

  mtll_head_tbl #(
    .NUM_SLOTS  (NUM_SLOTS),
    .MAX_TRAILS (MAX_TRAILS)
  ) u_heads (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid && cfg_wr.ready),
    .cfg_data  (cfg_wr.trail_count),
    .ctl       (head_ctl),
    .rd_trail  (head_rd_trail),
    .wr_trail  (head_wr_trail),
    .wr_link   (head_wr_link),
    .rr_trail  (rr_trail),
    .rd_link   (head_rd_link),
    .rd_in_use (head_in_use)
  );

  mtll_link_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .TR_W      (TR_W)
  ) u_links (
    .clk        (clk),
    .ctl        (mem_ctl),
    .rd_addr    (sidx),
    .pw_addr    (pw_addr),
    .pw_prev    (pw_prev),
    .pw_trail   (pw_trail),
    .nw_addr    (nw_addr),
    .nw_next    (nw_next),
    .rd_prev_r  (rd_prev),
    .rd_next_r  (rd_next),
    .rd_trail_r (rd_trail)
  );

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = in_rdy;

  assign in_fire   = in_req.valid && in_req.ready;
  assign sidx      = SIDX_W'(in_req.slot);
  assign in_range  = (32'(in_req.slot) < NUM_SLOTS);
  assign slot_live = live_r[sidx];
  assign in_reject = !in_range ||
                     ((in_req.func == mtll_pkg::FUNC_KILL) ? !slot_live : slot_live);
  assign out_free  = !out_valid_r || out_res.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtll_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_reject) begin
            state_nxt = mtll_pkg::ST_REJECT;
          end else if (in_req.func == mtll_pkg::FUNC_KILL) begin
            state_nxt = mtll_pkg::ST_KILL;
          end else begin
            state_nxt = mtll_pkg::ST_SPAWN;
          end
        end
      end
      mtll_pkg::ST_SPAWN, mtll_pkg::ST_KILL, mtll_pkg::ST_REJECT: begin
        if (out_free) begin
          state_nxt = mtll_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtll_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_rdy        = 1'b0;
    res_load      = 1'b0;
    live_set      = 1'b0;
    live_clr      = 1'b0;
    res_status    = mtll_pkg::STATUS_DONE;
    res_trail     = '0;
    res_link      = '0;
    head_ctl      = '0;
    head_rd_trail = rr_trail;
    head_wr_trail = rr_trail;
    head_wr_link  = {1'b0, sidx};
    mem_ctl       = '0;
    pw_addr       = sidx;
    pw_prev       = LINK_NONE;
    pw_trail      = rr_trail;
    nw_addr       = sidx;
    nw_next       = head_rd_link;
    unique case (state_r)
      mtll_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire && !in_reject) begin
          if (in_req.func == mtll_pkg::FUNC_KILL) begin
            mem_ctl.rd_en = 1'b1;
          end else begin
            // New entry becomes the head of the round-robin trail.
            head_ctl.take_rr  = 1'b1;
            head_ctl.set_head = 1'b1;
            mem_ctl.prev_we   = 1'b1;
            mem_ctl.trail_we  = 1'b1;
            mem_ctl.next_we   = 1'b1;
            live_set          = 1'b1;
          end
        end
      end
      mtll_pkg::ST_SPAWN: begin
        pw_addr = old_r[SIDX_W-1:0];
        pw_prev = {1'b0, slot_r};
        if (out_free) begin
          res_load        = 1'b1;
          mem_ctl.prev_we = !old_r[SIDX_W];
          res_trail       = t_r;
          res_link        = {1'b0, slot_r};
        end
      end
      mtll_pkg::ST_KILL: begin
        head_rd_trail = rd_trail;
        head_wr_trail = rd_trail;
        head_wr_link  = rd_next;
        pw_addr       = rd_next[SIDX_W-1:0];
        pw_prev       = rd_prev;
        nw_addr       = rd_prev[SIDX_W-1:0];
        nw_next       = rd_next;
        if (out_free) begin
          res_load  = 1'b1;
          live_clr  = 1'b1;
          res_trail = rd_trail;
          // A slot without a predecessor was the head of its trail, unless
          // that trail lies beyond the current trail count.
          if (!rd_prev[SIDX_W]) begin
            mem_ctl.next_we = 1'b1;
          end else if (head_in_use) begin
            head_ctl.set_head = 1'b1;
          end
          mem_ctl.prev_we = !rd_next[SIDX_W];
          if (!head_in_use) begin
            res_link = LINK_NONE;
          end else if (rd_prev[SIDX_W]) begin
            res_link = rd_next;
          end else begin
            res_link = head_rd_link;
          end
        end
      end
      mtll_pkg::ST_REJECT: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = mtll_pkg::STATUS_REJECT;
        end
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtll_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= sidx;
      old_r  <= head_rd_link;
      t_r    <= rr_trail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else begin
      if (live_set) begin
        live_r[sidx] <= 1'b1;
      end
      if (live_clr) begin
        live_r[slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= res_status;
      out_trail_r  <= mtll_pkg::TRAIL_W'(res_trail);
      out_head_r   <= res_link[SIDX_W] ? '0 : mtll_pkg::SLOT_W'(res_link[SIDX_W-1:0]);
      out_empty_r  <= res_link[SIDX_W];
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.status     = out_status_r;
  assign out_res.trail      = out_trail_r;
  assign out_res.head_slot  = out_head_r;
  assign out_res.head_empty = out_empty_r;

  // An accepted request always enters a processing state.
  `ASSERT_NXT(a_fire_leaves_idle, clk, rst_n, in_fire, state_r != mtll_pkg::ST_IDLE)

  // The kill completion state is entered only after its link read was issued.
  `ASSERT_IMP(a_kill_after_read, clk, rst_n, (state_r == mtll_pkg::ST_KILL) && ($past(state_r) == mtll_pkg::ST_IDLE), $past(mem_ctl.rd_en))

  // A completed spawn leaves its slot live.
  `ASSERT_NXT(a_spawn_sets_live, clk, rst_n, (state_r == mtll_pkg::ST_SPAWN) && out_free, live_r[slot_r])

  // A completed kill leaves its slot dead.
  `ASSERT_NXT(a_kill_clears_live, clk, rst_n, (state_r == mtll_pkg::ST_KILL) && out_free, !live_r[slot_r])

endmodule
